[src/rcr_pkg.sv]
// Shared types and constants for the rectangle canvas rasteriser.
// Used by rcr_ctrl, rcr_datapath and the top level; no dependencies.
package rcr_pkg;

  // Field widths fixed by the interface
  localparam int CfgW   = 9;
  localparam int CoordW = 24;
  localparam int OffW   = 26;

  // One pixel step in Q.8 fixed point
  localparam logic signed [OffW-1:0] OneQ8 = 26'sd256;

  // Register reset values
  localparam logic [CfgW-1:0] CanvasWidthReset  = 9'd256;
  localparam logic [CfgW-1:0] CanvasHeightReset = 9'd256;
  localparam logic [7:0]      BackgroundReset   = 8'd32;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_DRAW  = 2'd1,
    FUNC_READ  = 2'd2
  } func_e_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_OOB    = 2'd2
  } status_e_t;

  typedef enum logic [1:0] {
    CFG_CANVAS_WIDTH  = 2'd0,
    CFG_CANVAS_HEIGHT = 2'd1,
    CFG_BACKGROUND    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_DRAW,
    S_READ,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic clear_mode;
    logic read_mem;
    logic result_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;
    logic draw_reject;
    logic out_full;
  } sts_t;

endpackage

[src/rcr_ctrl.sv]
// Sequencing state machine of the rectangle canvas rasteriser.
// Depends on rcr_pkg; drives rcr_datapath through cmd_t and reads sts_t.
module rcr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    func,
  output logic          in_ready,
  output rcr_pkg::cmd_t cmd,
  input  rcr_pkg::sts_t sts
);
  import rcr_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (func_e_t'(func))
            FUNC_CLEAR: state_next = S_CLEAR;
            FUNC_DRAW:  state_next = sts.draw_reject ? S_DONE : S_DRAW;
            FUNC_READ:  state_next = S_READ;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.step       = 1'b1;
        cmd.clear_mode = 1'b1;
        if (sts.last) begin
          state_next = S_DONE;
        end
      end
      S_DRAW: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        cmd.read_mem = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output slot is free
        if (!sts.out_full) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("accepted item did not start work");

  a_result_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |=> (state == S_IDLE))
    else $error("result load did not return to idle");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_DONE))
    else $error("pixel read took more than one cycle");
`endif

endmodule

[src/rcr_datapath.sv]
// Datapath of the rectangle canvas rasteriser: config registers, scan
// counters, edge offsets, canvas memory and result register. Uses rcr_pkg.
module rcr_datapath #(
  parameter int MAX_SIDE = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [rcr_pkg::CfgW-1:0]           cfg_data,
  input  logic [1:0]                         func,
  input  logic                               filled,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_left,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_top,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_width,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_height,
  input  logic [7:0]                         rect_color,
  input  logic [7:0]                         pixel_row,
  input  logic [7:0]                         pixel_col,
  input  rcr_pkg::cmd_t                      cmd,
  output rcr_pkg::sts_t                      sts,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [7:0]                         pixel_value,
  output logic [1:0]                         status
);
  import rcr_pkg::*;

  localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int AW = 2 * CW;
  localparam int EW = (CW + 1 > CfgW) ? CW + 1 : CfgW;
  localparam logic [CW-1:0] MaxLim = CW'(MAX_SIDE - 1);

  // Configuration registers
  logic [CfgW-1:0] canvas_width;
  logic [CfgW-1:0] canvas_height;
  logic [7:0]      background;

  // Latched item
  logic            filled_q;
  logic [7:0]      color_q;
  logic [AW-1:0]   rd_addr;
  logic            rd_ok;
  logic [1:0]      status_q;

  // Scan state
  logic [CW-1:0]        row;
  logic [CW-1:0]        col;
  logic signed [OffW-1:0] neg_left;
  logic signed [OffW-1:0] right;
  logic signed [OffW-1:0] dxl;
  logic signed [OffW-1:0] dxr;
  logic signed [OffW-1:0] dyt;
  logic signed [OffW-1:0] dyb;

  // Canvas memory
  logic [7:0] mem [2**AW];
  logic [7:0] rd_q;

  logic [CW-1:0] lim_w;
  logic [CW-1:0] lim_h;
  logic [EW-1:0] cw_ext;
  logic [EW-1:0] ch_ext;
  logic [CW-1:0] cur_lw;
  logic [CW-1:0] cur_lh;
  logic          last_col;
  logic          in_box;
  logic          edge_band;
  logic          mem_we;
  logic [7:0]    wdata;
  logic          row_oob;
  logic          col_oob;
  logic signed [OffW-1:0] l_ext;
  logic signed [OffW-1:0] t_ext;
  logic signed [OffW-1:0] w_ext;
  logic signed [OffW-1:0] h_ext;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CanvasWidthReset;
      canvas_height <= CanvasHeightReset;
      background    <= BackgroundReset;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        CFG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        CFG_BACKGROUND:    background    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Clamp the canvas size to 1..MAX_SIDE, kept as last index
  always_comb begin
    cw_ext = EW'(canvas_width);
    ch_ext = EW'(canvas_height);
    if (cw_ext == '0) begin
      lim_w = '0;
    end else if (cw_ext > EW'(MAX_SIDE)) begin
      lim_w = MaxLim;
    end else begin
      lim_w = CW'(cw_ext - 1'b1);
    end
    if (ch_ext == '0) begin
      lim_h = '0;
    end else if (ch_ext > EW'(MAX_SIDE)) begin
      lim_h = MaxLim;
    end else begin
      lim_h = CW'(ch_ext - 1'b1);
    end
  end

  // Decode the incoming item
  assign l_ext   = {{(OffW-CoordW){rect_left[CoordW-1]}}, rect_left};
  assign t_ext   = {{(OffW-CoordW){rect_top[CoordW-1]}}, rect_top};
  assign w_ext   = {{(OffW-CoordW){rect_width[CoordW-1]}}, rect_width};
  assign h_ext   = {{(OffW-CoordW){rect_height[CoordW-1]}}, rect_height};
  assign row_oob = EW'(pixel_row) > EW'(lim_h);
  assign col_oob = EW'(pixel_col) > EW'(lim_w);

  assign sts.draw_reject = rect_width[CoordW-1] || (rect_width == '0) ||
                           rect_height[CoordW-1] || (rect_height == '0);

  // Scan limits and pixel coverage
  assign cur_lw   = cmd.clear_mode ? MaxLim : lim_w;
  assign cur_lh   = cmd.clear_mode ? MaxLim : lim_h;
  assign last_col = (col == cur_lw);
  assign sts.last = last_col && (row == cur_lh);

  assign in_box    = !dxl[OffW-1] && !dxr[OffW-1] && !dyt[OffW-1] && !dyb[OffW-1];
  assign edge_band = (dxl < OneQ8) || (dxr < OneQ8) || (dyt < OneQ8) || (dyb < OneQ8);
  assign mem_we    = cmd.step && (cmd.clear_mode || (in_box && (edge_band || filled_q)));
  assign wdata     = cmd.clear_mode ? background : color_q;

  // Latch the item and advance the scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      filled_q <= filled;
      color_q  <= rect_color;
      rd_addr  <= {CW'(pixel_row), CW'(pixel_col)};
      rd_ok    <= 1'b0;
      status_q <= STATUS_OK;
      case (func_e_t'(func))
        FUNC_DRAW: begin
          if (sts.draw_reject) begin
            status_q <= STATUS_REJECT;
          end
        end
        FUNC_READ: begin
          if (row_oob || col_oob) begin
            status_q <= STATUS_OOB;
          end else begin
            rd_ok <= 1'b1;
          end
        end
        default: ;
      endcase
      row      <= '0;
      col      <= '0;
      neg_left <= -l_ext;
      right    <= l_ext + w_ext;
      dxl      <= -l_ext;
      dxr      <= l_ext + w_ext;
      dyt      <= -t_ext;
      dyb      <= t_ext + h_ext;
    end else if (cmd.step) begin
      if (last_col) begin
        col <= '0;
        row <= row + 1'b1;
        dxl <= neg_left;
        dxr <= right;
        dyt <= dyt + OneQ8;
        dyb <= dyb - OneQ8;
      end else begin
        col <= col + 1'b1;
        dxl <= dxl + OneQ8;
        dxr <= dxr - OneQ8;
      end
    end
  end

  // Canvas memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{row, col}] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_mem) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Result register
  assign sts.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      pixel_value <= rd_ok ? rd_q : 8'd0;
      status      <= status_q;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> !(out_valid && !out_ready))
    else $error("result loaded over a waiting item");

  a_scan_starts_at_origin: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (row == '0 && col == '0))
    else $error("scan did not start at the origin");

  a_row_holds_in_line: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !last_col) |=> (row == $past(row)))
    else $error("row moved before the end of the line");
`endif

endmodule

[src/rectangle_canvas_rasterizer.sv]
// Rectangle canvas rasteriser: one item at a time, one canvas pixel per cycle.
// A clear sweeps the whole MAX_SIDE x MAX_SIDE store; a draw scans the canvas in
// use, eff_width x eff_height pixels, eff_ being the size registers clamped to
// 1..MAX_SIDE; a rejected rectangle and an unused function code go straight to
// the result, and a read looks up one pixel. The scan speed is set by the single
// write port of the canvas memory, visited once per pixel by the scan counters.
// The canvas holds no defined value after reset until a clear has swept it. A
// new item is taken while a result waits at the output.
// Depends on rcr_pkg, rcr_ctrl and rcr_datapath.
module rectangle_canvas_rasterizer #(
  parameter int MAX_SIDE = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [rcr_pkg::CfgW-1:0]           cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         func,
  input  logic                               filled,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_left,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_top,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_width,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_height,
  input  logic [7:0]                         rect_color,
  input  logic [7:0]                         pixel_row,
  input  logic [7:0]                         pixel_col,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         pixel_value,
  output logic [1:0]                         status
);
  import rcr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  rcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Scan, canvas and result
  rcr_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .filled      (filled),
    .rect_left   (rect_left),
    .rect_top    (rect_top),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .rect_color  (rect_color),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .pixel_value (pixel_value),
    .status      (status)
  );

endmodule
